/* sv/echt_pkg.sv */
// Package for the event coalescing history table: field widths, action and
// status codes, and the queue entry type shared by front and back end.
// No dependencies.
`default_nettype none
package echt_pkg;
    localparam int GROUPS_DEF = 40;
    localparam int DUPES_DEF  = 10;
    localparam logic [31:0] ID_MAX = 32'hFFFF_FFFF;

    localparam logic [1:0] ACT_NEW     = 2'd0;
    localparam logic [1:0] ACT_RESTORE = 2'd1;
    localparam logic [1:0] ACT_DELETE  = 2'd2;
    localparam logic [1:0] ACT_CLEAR   = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_CLEARED  = 2'd2;

    // Command passed from the front end to the back end.
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] id;      // resolved id for new/restore, match id for delete
        logic [31:0] ev_time;
        logic [7:0]  severity;
        logic [15:0] code;
        logic [7:0]  response;
        logic [15:0] key;
        logic [15:0] detail;
    } t_cmd;

    // Result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot;
        logic [31:0] id;
        logic        evicted;
        logic [3:0]  fill;
        logic [8:0]  removed;
    } t_res;
endpackage
`default_nettype wire

/* sv/event_coalescing_history_table.sv */
// Event coalescing history table, top level. Uses echt_pkg, echt_front, echt_back.
// Commands pass through the front queue to the back end. New/restore scans the
// slots for a key match, else takes the lowest free slot or evicts the oldest
// group, then shifts that group's records down to put the new one first; delete
// scans every slot and compacts out matching records; clear walks all slots.
// Throughput: one item at a time in the back end; the front queue holds two.
// Synchronous active-low reset empties all groups and sets the id counter to 1.
`default_nettype none
module event_coalescing_history_table
    import echt_pkg::*;
#(
    parameter int GROUPS = GROUPS_DEF,
    parameter int DUPES  = DUPES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // action[1:0], record_id[33:2], event_time[65:34], severity[73:66],
    // alarm_code[89:74], alarm_response[97:90], group_key[113:98],
    // detail_handle[129:114], zero fill to 136
    input  wire logic [135:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[1:0], group_slot[7:2], assigned_id[39:8], evicted[40],
    // group_fill[44:41], removed_count[53:45], zero fill to 56
    output logic [55:0]       m_axis_tdata
);
    t_cmd w_in, w_q;
    t_res w_res;
    logic w_qv, w_pop;

    assign w_in = '{action: s_axis_tdata[1:0], id: s_axis_tdata[33:2],
                    ev_time: s_axis_tdata[65:34], severity: s_axis_tdata[73:66],
                    code: s_axis_tdata[89:74], response: s_axis_tdata[97:90],
                    key: s_axis_tdata[113:98], detail: s_axis_tdata[129:114]};

    echt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(w_in),
        .o_valid(w_qv), .i_pop(w_pop), .o_cmd(w_q)
    );

    echt_back #(.GROUPS(GROUPS), .DUPES(DUPES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_pop(w_pop), .i_cmd(w_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {2'b00, w_res.removed, w_res.fill, w_res.evicted,
                           w_res.id, w_res.slot, w_res.status};
endmodule
`default_nettype wire

/* sv/echt_front.sv */
// Front end: accepts input transfers, resolves record ids from the id
// counter and pushes commands into a two-entry queue. Uses echt_pkg.
`default_nettype none
module echt_front
    import echt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_cmd       i_cmd,
    output logic            o_valid,
    input  wire logic       i_pop,
    output t_cmd            o_cmd
);
    t_cmd        r_q [2];
    logic        r_rd, r_wr;
    logic [1:0]  r_cnt;
    logic [31:0] r_idc;
    t_cmd        w_cmd;
    logic        w_push;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rd];
    assign w_push  = i_valid && o_ready;

    always_comb begin
        w_cmd = i_cmd;
        if (i_cmd.action == ACT_NEW) w_cmd.id = r_idc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
            r_idc <= 32'd1;
        end else begin
            if (w_push) begin
                r_q[r_wr] <= w_cmd;
                r_wr      <= ~r_wr;
                if (i_cmd.action == ACT_NEW)
                    r_idc <= r_idc + 32'd1;
                else if (i_cmd.action == ACT_RESTORE && i_cmd.id >= r_idc)
                    r_idc <= i_cmd.id + 32'd1;
            end
            if (i_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            assert (!(i_pop && r_cnt == 2'd0)) else $error("pop from empty queue");
        end
    end
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_new_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && i_cmd.action == ACT_NEW) |=> r_idc == $past(r_idc) + 32'd1)
        else $error("id counter not advanced");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop without command");
endmodule
`default_nettype wire

/* sv/echt_back.sv */
// Back end: slot table and record memory, a sequencer that scans slots and
// records in turn. Uses echt_pkg.
`default_nettype none
module echt_back
    import echt_pkg::*;
#(
    parameter int GROUPS = GROUPS_DEF,
    parameter int DUPES  = DUPES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_pop,
    input  wire t_cmd i_cmd,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_res      o_res
);
    localparam int CAP  = 1 + DUPES;
    localparam int ENT  = GROUPS * CAP;
    localparam int SW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int SCW  = $clog2(GROUPS + 1);
    localparam int RW   = $clog2(CAP + 1);
    localparam int AW   = (ENT > 1) ? $clog2(ENT) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_MATCH, S_FREE, S_OLD, S_SETUP, S_SHIFT_RD, S_SHIFT_WR,
        S_PUT, S_DEL_SLOT, S_DEL_RD, S_DEL_WR, S_DEL_END, S_CLEAR, S_OUT
    } t_state;

    typedef struct packed {
        logic [7:0]  sev;
        logic [15:0] code;
        logic [7:0]  resp;
        logic [15:0] key;
        logic [RW-1:0] fill;
        logic [31:0] latest;
    } t_slot;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] tm;
        logic [15:0] det;
    } t_ent;

    // Slot table is scanned by one counter, so it is a memory read one
    // address a cycle; used bits stay in flops.
    t_slot          r_slot [GROUPS];
    logic [GROUPS-1:0] r_used;
    t_ent           r_mem [ENT];

    t_state         r_st;
    t_cmd           r_cmd;
    logic [SCW-1:0] r_s;      // scan index
    logic [SW-1:0]  r_hit;
    logic           r_found, r_ev;
    logic [31:0]    r_best;
    logic [RW-1:0]  r_r, r_kept, r_n;
    logic [AW-1:0]  r_base;
    logic [8:0]     r_total;
    t_slot          r_sd;     // registered slot read
    t_ent           r_ed;     // registered entry read
    logic [31:0]    r_first_tm;
    t_res           r_res;
    logic           r_ovalid;

    assign o_valid = r_ovalid;
    assign o_res   = r_res;
    assign o_pop   = (r_st == S_IDLE) && i_valid && !r_ovalid;

    logic [SW-1:0] w_s;
    assign w_s = r_s[SW-1:0];

    logic w_last;
    assign w_last = (r_s == SCW'(GROUPS - 1));

    // lowest free slot
    logic          w_free_any;
    logic [SW-1:0] w_free_idx;
    always_comb begin
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (!r_used[g]) begin
                w_free_any = 1'b1;
                w_free_idx = SW'(g);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd <= r_slot[w_s];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_st == S_OUT && (!r_ovalid || i_ready)) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd   <= i_cmd;
                        r_s     <= '0;
                        r_found <= 1'b0;
                        r_ev    <= 1'b0;
                        r_total <= '0;
                        unique case (i_cmd.action)
                            ACT_NEW, ACT_RESTORE: r_st <= S_MATCH;
                            ACT_DELETE:           r_st <= S_DEL_SLOT;
                            default:              r_st <= S_CLEAR;
                        endcase
                    end
                end
                // r_sd holds slot r_s-1 once r_s is nonzero, so the compare is made in the
                // cycle after the address.
                S_MATCH: begin
                    if (r_s != '0 && !r_found && r_used[SW'(r_s - 1'b1)] &&
                        r_sd.sev == r_cmd.severity && r_sd.code == r_cmd.code &&
                        r_sd.resp == r_cmd.response && r_sd.key == r_cmd.key) begin
                        r_found <= 1'b1;
                        r_hit   <= SW'(r_s - 1'b1);
                    end
                    if (r_s == SCW'(GROUPS)) begin
                        r_s <= '0;
                        r_st <= S_FREE;
                    end else begin
                        r_s <= r_s + 1'b1;
                    end
                end
                S_FREE: begin
                    if (r_found) begin
                        // pass through S_OLD so r_sd holds the matched slot
                        r_s  <= SCW'(r_hit);
                        r_st <= S_OLD;
                    end else begin
                        r_st <= S_OLD;
                        if (w_free_any) begin
                            r_hit   <= w_free_idx;
                            r_found <= 1'b1;
                        end
                        r_best <= ID_MAX;
                        r_s    <= '0;
                    end
                end
                S_OLD: begin
                    if (r_found) begin
                        r_st <= S_SETUP;
                        r_s  <= SCW'(r_hit);
                    end else begin
                        if (r_s != '0 && (r_s == SCW'(1) || r_sd.latest < r_best)) begin
                            r_best <= r_sd.latest;
                            r_hit  <= SW'(r_s - 1'b1);
                        end
                        if (r_s == SCW'(GROUPS)) begin
                            r_ev    <= 1'b1;
                            r_found <= 1'b1;
                        end else begin
                            r_s <= r_s + 1'b1;
                        end
                    end
                end
                S_SETUP: begin
                    // new group if this slot was not a key match in use
                    if (!r_used[r_hit] || r_ev ||
                        !(r_sd.sev == r_cmd.severity && r_sd.code == r_cmd.code &&
                          r_sd.resp == r_cmd.response && r_sd.key == r_cmd.key) ||
                        r_s != SCW'(r_hit)) begin
                        r_n <= RW'(1);
                    end else begin
                        r_n <= (r_sd.fill < RW'(CAP)) ? r_sd.fill + 1'b1 : RW'(CAP);
                    end
                    r_base <= AW'(r_hit * CAP);
                    r_st   <= S_SHIFT_RD;
                    r_r    <= '0;
                end
                S_SHIFT_RD: begin
                    if (r_r == '0) r_r <= r_n;
                    if (r_r == RW'(1) || r_n == RW'(1)) begin
                        r_st <= S_PUT;
                    end else begin
                        if (r_r != '0) begin
                            r_ed <= r_mem[r_base + AW'(r_r) - AW'(2)];
                            r_st <= S_SHIFT_WR;
                        end
                    end
                end
                S_SHIFT_WR: begin
                    r_mem[r_base + AW'(r_r) - AW'(1)] <= r_ed;
                    r_r  <= r_r - 1'b1;
                    r_st <= S_SHIFT_RD;
                end
                S_PUT: begin
                    r_mem[r_base] <= '{id: r_cmd.id, tm: r_cmd.ev_time,
                                       det: r_cmd.detail};
                    r_used[r_hit] <= 1'b1;
                    r_slot[r_hit] <= '{sev: r_cmd.severity, code: r_cmd.code,
                                       resp: r_cmd.response, key: r_cmd.key,
                                       fill: r_n, latest: r_cmd.ev_time};
                    r_res <= '{status: ST_DONE, slot: 6'(r_hit), id: r_cmd.id,
                               evicted: r_ev, fill: 4'(r_n), removed: '0};
                    r_st <= S_OUT;
                end
                S_DEL_SLOT: begin
                    if (r_s == SCW'(GROUPS)) begin
                        r_res <= '{status: (r_total == '0) ? ST_NOTFOUND : ST_DONE,
                                   slot: '0, id: '0, evicted: 1'b0, fill: '0,
                                   removed: r_total};
                        r_st  <= S_OUT;
                    end else if (!r_used[w_s]) begin
                        r_s <= r_s + 1'b1;
                    end else begin
                        r_base <= AW'(w_s * CAP);
                        r_r    <= '0;
                        r_kept <= '0;
                        r_st   <= S_DEL_RD;
                    end
                end
                S_DEL_RD: begin
                    // r_sd is valid for slot r_s here
                    if (r_r >= r_sd.fill || r_r >= RW'(CAP)) begin
                        r_st <= S_DEL_END;
                    end else begin
                        r_ed <= r_mem[r_base + AW'(r_r)];
                        r_st <= S_DEL_WR;
                    end
                end
                S_DEL_WR: begin
                    if (r_ed.id == r_cmd.id) begin
                        if (r_total != 9'd511) r_total <= r_total + 1'b1;
                    end else begin
                        r_mem[r_base + AW'(r_kept)] <= r_ed;
                        if (r_kept == '0) r_first_tm <= r_ed.tm;
                        r_kept <= r_kept + 1'b1;
                    end
                    r_r  <= r_r + 1'b1;
                    r_st <= S_DEL_RD;
                end
                S_DEL_END: begin
                    if (r_kept == '0) begin
                        r_used[w_s] <= 1'b0;
                        r_slot[w_s] <= '0;
                    end else begin
                        r_slot[w_s] <= '{sev: r_sd.sev, code: r_sd.code,
                                         resp: r_sd.resp, key: r_sd.key,
                                         fill: r_kept, latest: r_first_tm};
                    end
                    r_s  <= r_s + 1'b1;
                    r_st <= S_DEL_SLOT;
                end
                S_CLEAR: begin
                    r_slot[w_s] <= '0;
                    r_used      <= '0;
                    if (w_last) begin
                        r_res <= '{status: ST_CLEARED, slot: '0, id: '0,
                                   evicted: 1'b0, fill: '0, removed: '0};
                        r_st  <= S_OUT;
                    end else begin
                        r_s <= r_s + 1'b1;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_ovalid) else $error("pop while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> r_ovalid) else $error("result dropped");
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_PUT) |-> (r_n != '0 && r_n <= RW'(CAP))) else $error("bad fill");
endmodule
`default_nettype wire
